FILE: rtl/sbm_pkg.sv
// shared types, constants and mode codes of the spectral blend-mode alu
// no dependencies; compiled first
package sbm_pkg;

  localparam int unsigned LANES_DEF   = 4;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;
  localparam int unsigned PIPE_STAGES = 5;
  localparam int unsigned DIV_STEPS   = 4;
  localparam int          ONE_Q       = 4096;
  localparam int          HALF_Q      = 2048;

  // register index, taken from paddr[2]
  localparam logic REG_MODE = 1'b0;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [3:0] {
    MODE_ADD    = 4'd0,
    MODE_SUB    = 4'd1,
    MODE_MUL    = 4'd2,
    MODE_DIV    = 4'd3,
    MODE_NEG    = 4'd4,
    MODE_ABS    = 4'd5,
    MODE_MAX    = 4'd6,
    MODE_MIN    = 4'd7,
    MODE_BURN   = 4'd8,
    MODE_SCREEN = 4'd9,
    MODE_DODGE  = 4'd10,
    MODE_OVERLAY= 4'd11,
    MODE_SOFT   = 4'd12,
    MODE_HARD   = 4'd13,
    MODE_BLEND  = 4'd14,
    MODE_BC     = 4'd15
  } mode_e;

  typedef struct packed {
    logic  en;
    mode_e mode;
  } lane_ctrl_t;

endpackage

FILE: rtl/sbm_if.sv
// stream interfaces of the spectral blend-mode alu: operand and result channels
// depends on sbm_pkg
interface sbm_in_if #(parameter int unsigned LANES = sbm_pkg::LANES_DEF);
  import sbm_pkg::*;

  logic                   valid;
  logic                   ready;
  sample_t [LANES-1:0]    a_lane;
  sample_t [LANES-1:0]    b_lane;
  sample_t                mix_factor;
  sample_t                brightness;
  sample_t                contrast;

  modport source (output valid, a_lane, b_lane, mix_factor, brightness, contrast,
                  input ready);
  modport sink   (input valid, a_lane, b_lane, mix_factor, brightness, contrast,
                  output ready);
endinterface

interface sbm_out_if #(parameter int unsigned LANES = sbm_pkg::LANES_DEF);
  import sbm_pkg::*;

  logic                   valid;
  logic                   ready;
  sample_t [LANES-1:0]    r_lane;
  logic                   zero_divide;

  modport source (output valid, r_lane, zero_divide, input ready);
  modport sink   (input valid, r_lane, zero_divide, output ready);
endinterface

FILE: rtl/sbm_lane.sv
// one lane of the blend-mode datapath: five register stages, two multiply
// levels and a 16-step restoring divider at four steps a stage; uses sbm_pkg
module sbm_lane (
  input  logic                clk_i,
  input  sbm_pkg::lane_ctrl_t ctrl_i,
  input  sbm_pkg::sample_t    a_i,
  input  sbm_pkg::sample_t    b_i,
  input  sbm_pkg::sample_t    f_i,
  input  sbm_pkg::sample_t    br_i,
  input  sbm_pkg::sample_t    ct_i,
  output sbm_pkg::sample_t    res_o,
  output logic                zd_o
);
  import sbm_pkg::*;

  localparam logic signed [19:0] ONE_W  = 20'(ONE_Q);
  localparam logic signed [19:0] HALF_W = 20'(HALF_Q);

  typedef struct packed {
    logic [16:0] rem;
    logic [15:0] nq;
  } div_st_t;

  function automatic div_st_t div_steps(div_st_t s, logic [16:0] d);
    div_st_t     t;
    logic [17:0] sh;
    logic        ge;
    t = s;
    for (int k = 0; k < DIV_STEPS; k++) begin
      sh = {t.rem, t.nq[15]};
      ge = (sh >= {1'b0, d});
      t.rem = ge ? 17'(sh - {1'b0, d}) : sh[16:0];
      t.nq  = {t.nq[14:0], ge};
    end
    return t;
  endfunction

  // stage 0 decode
  logic signed [19:0] a_w, b_w, f_w, om_a, om_b, om_f;
  logic signed [18:0] x1_d, y1_d, x2_d, y2_d;
  logic signed [29:0] c1_d;
  logic signed [17:0] sr_d, num, den;
  logic               hls_d, isdiv;
  logic [16:0]        n_mag, d_mag;
  logic [28:0]        n_full;
  logic               ovf_d, qz_d, neg_d, zd_d;
  div_st_t            dv_d;

  assign a_w  = a_i;
  assign b_w  = b_i;
  assign f_w  = f_i;
  assign om_a = ONE_W - a_w;
  assign om_b = ONE_W - b_w;
  assign om_f = ONE_W - f_w;

  always_comb begin
    x1_d  = '0;
    y1_d  = '0;
    x2_d  = '0;
    y2_d  = '0;
    hls_d = 1'b0;
    case (ctrl_i.mode)
      MODE_MUL: begin
        x1_d = 19'(a_w);
        y1_d = 19'(b_w);
      end
      MODE_SCREEN: begin
        x1_d = 19'(om_a);
        y1_d = 19'(om_b);
      end
      MODE_HARD: begin
        if (b_w <= HALF_W) begin
          x1_d = 19'(b_w <<< 1);
          y1_d = 19'(a_w);
        end else begin
          x1_d  = 19'((ONE_W <<< 1) - (b_w <<< 1));
          y1_d  = 19'(om_a);
          hls_d = 1'b1;
        end
      end
      MODE_OVERLAY: begin
        x1_d = 19'(b_w);
        y1_d = 19'(om_a);
      end
      MODE_SOFT: begin
        x1_d = 19'(om_a);
        y1_d = 19'(b_w);
        x2_d = 19'(om_a);
        y2_d = 19'(om_b);
      end
      MODE_BLEND: begin
        x1_d = 19'(a_w);
        y1_d = 19'(om_f);
        x2_d = 19'(b_w);
        y2_d = 19'(f_w);
      end
      MODE_BC: begin
        x1_d = 19'(ONE_W + 20'(ct_i));
        y1_d = 19'(a_w);
      end
      default: ;
    endcase
  end

  // brightness*1.0 - contrast*0.5 at q6.24
  assign c1_d = (30'(br_i) <<< 12) - (30'(ct_i) <<< 11);

  always_comb begin
    case (ctrl_i.mode)
      MODE_ADD: sr_d = 18'(a_i) + 18'(b_i);
      MODE_SUB: sr_d = 18'(a_i) - 18'(b_i);
      MODE_NEG: sr_d = -18'(a_i);
      MODE_ABS: sr_d = a_i[15] ? -18'(a_i) : 18'(a_i);
      MODE_MAX: sr_d = (a_i > b_i) ? 18'(a_i) : 18'(b_i);
      MODE_MIN: sr_d = (a_i < b_i) ? 18'(a_i) : 18'(b_i);
      default:  sr_d = '0;
    endcase
  end

  always_comb begin
    isdiv = 1'b1;
    case (ctrl_i.mode)
      MODE_DIV: begin
        num = 18'(a_w);
        den = 18'(b_w);
      end
      MODE_BURN: begin
        num = 18'(om_a);
        den = 18'(b_w + ONE_W);
      end
      MODE_DODGE: begin
        num = 18'(a_w);
        den = 18'((ONE_W <<< 1) - b_w);
      end
      default: begin
        num   = '0;
        den   = '0;
        isdiv = 1'b0;
      end
    endcase
  end

  assign n_mag  = num[17] ? 17'(-num) : num[16:0];
  assign d_mag  = den[17] ? 17'(-den) : den[16:0];
  assign n_full = {n_mag, 12'b0};

  always_comb begin
    if (den == '0) begin
      ovf_d = (num != '0);
      qz_d  = (num == '0);
      neg_d = num[17];
    end else begin
      ovf_d = ({4'b0, n_full} >= {d_mag, 16'b0});
      qz_d  = 1'b0;
      neg_d = num[17] ^ den[17];
    end
  end

  assign zd_d     = isdiv && (den == '0);
  assign dv_d.rem = {4'b0, n_full[28:16]};
  assign dv_d.nq  = n_full[15:0];

  // stage 1
  mode_e              mode1_q;
  sample_t            a1_q;
  logic signed [17:0] sr1_q;
  logic signed [18:0] x1_q, y1_q, x2_q, y2_q;
  logic signed [29:0] c1_q;
  div_st_t            dv1_q;
  logic [16:0]        d1_q;
  logic               ovf1_q, qz1_q, neg1_q, zd1_q, hls1_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      mode1_q <= ctrl_i.mode;
      a1_q    <= a_i;
      sr1_q   <= sr_d;
      x1_q    <= x1_d;
      y1_q    <= y1_d;
      x2_q    <= x2_d;
      y2_q    <= y2_d;
      c1_q    <= c1_d;
      dv1_q   <= dv_d;
      d1_q    <= d_mag;
      ovf1_q  <= ovf_d;
      qz1_q   <= qz_d;
      neg1_q  <= neg_d;
      zd1_q   <= zd_d;
      hls1_q  <= hls_d;
    end
  end

  // stage 2: first products, divider steps 15..12
  mode_e              mode2_q;
  sample_t            a2_q;
  logic signed [17:0] sr2_q;
  logic signed [37:0] p1_q, p2_q;
  logic signed [29:0] c2_q;
  div_st_t            dv2_q;
  logic [16:0]        d2_q;
  logic               ovf2_q, qz2_q, neg2_q, zd2_q, hls2_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      mode2_q <= mode1_q;
      a2_q    <= a1_q;
      sr2_q   <= sr1_q;
      p1_q    <= x1_q * y1_q;
      p2_q    <= x2_q * y2_q;
      c2_q    <= c1_q;
      dv2_q   <= div_steps(dv1_q, d1_q);
      d2_q    <= d1_q;
      ovf2_q  <= ovf1_q;
      qz2_q   <= qz1_q;
      neg2_q  <= neg1_q;
      zd2_q   <= zd1_q;
      hls2_q  <= hls1_q;
    end
  end

  // rounding of first products and second multiplier operand
  logic signed [37:0] t1, t2;
  logic signed [25:0] m1, m2;
  logic signed [38:0] sb, sc;
  logic signed [26:0] rbc;
  logic signed [27:0] r3_d, x3_d;

  assign t1  = p1_q + 38'sd2048;
  assign t2  = p2_q + 38'sd2048;
  assign m1  = $signed(t1[37:12]);
  assign m2  = $signed(t2[37:12]);
  assign sb  = 39'(p1_q) + 39'(p2_q) + 39'sd2048;
  assign sc  = 39'(p1_q) + 39'(c2_q) + 39'sd2048;
  assign rbc = $signed(sc[38:12]);

  always_comb begin
    r3_d = '0;
    x3_d = '0;
    case (mode2_q)
      MODE_MUL:     r3_d = 28'(m1);
      MODE_SCREEN:  r3_d = 28'(ONE_W) - 28'(m1);
      MODE_HARD:    r3_d = hls2_q ? 28'(ONE_W) - 28'(m1) : 28'(m1);
      MODE_BLEND:   r3_d = 28'($signed(sb[38:12]));
      MODE_BC:      r3_d = rbc[26] ? '0 : 28'(rbc);
      MODE_OVERLAY: x3_d = 28'(a2_q) + (28'(m1) <<< 1);
      MODE_SOFT:    x3_d = 28'(m1) + 28'(ONE_W) - 28'(m2);
      default: ;
    endcase
  end

  // stage 3, divider steps 11..8
  mode_e              mode3_q;
  sample_t            a3_q;
  logic signed [17:0] sr3_q;
  logic signed [27:0] r3_q, x3_q;
  div_st_t            dv3_q;
  logic [16:0]        d3_q;
  logic               ovf3_q, qz3_q, neg3_q, zd3_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      mode3_q <= mode2_q;
      a3_q    <= a2_q;
      sr3_q   <= sr2_q;
      r3_q    <= r3_d;
      x3_q    <= x3_d;
      dv3_q   <= div_steps(dv2_q, d2_q);
      d3_q    <= d2_q;
      ovf3_q  <= ovf2_q;
      qz3_q   <= qz2_q;
      neg3_q  <= neg2_q;
      zd3_q   <= zd2_q;
    end
  end

  // stage 4: second product, divider steps 7..4
  mode_e              mode4_q;
  logic signed [17:0] sr4_q;
  logic signed [27:0] r4_q;
  logic signed [43:0] p3_q;
  div_st_t            dv4_q;
  logic [16:0]        d4_q;
  logic               ovf4_q, qz4_q, neg4_q, zd4_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      mode4_q <= mode3_q;
      sr4_q   <= sr3_q;
      r4_q    <= r3_q;
      p3_q    <= x3_q * a3_q;
      dv4_q   <= div_steps(dv3_q, d3_q);
      d4_q    <= d3_q;
      ovf4_q  <= ovf3_q;
      qz4_q   <= qz3_q;
      neg4_q  <= neg3_q;
      zd4_q   <= zd3_q;
    end
  end

  // last divider steps, sign, mode select and saturation
  logic signed [43:0] t3;
  logic signed [31:0] m3;
  div_st_t            dv5;
  logic signed [23:0] qv, qpos;
  logic signed [24:0] divres;
  logic signed [32:0] val;
  sample_t            sat_d;

  assign t3   = p3_q + 44'sd2048;
  assign m3   = $signed(t3[43:12]);
  assign dv5  = div_steps(dv4_q, d4_q);
  assign qpos = $signed({8'b0, dv5.nq});

  always_comb begin
    if (qz4_q) begin
      qv = '0;
    end else if (ovf4_q) begin
      qv = neg4_q ? -24'sd1048576 : 24'sd1048576;
    end else begin
      qv = neg4_q ? -qpos : qpos;
    end
  end

  assign divres = (mode4_q == MODE_BURN) ? 25'(ONE_W) - 25'(qv) : 25'(qv);

  always_comb begin
    case (mode4_q) inside
      MODE_ADD, MODE_SUB, MODE_NEG, MODE_ABS, MODE_MAX, MODE_MIN: val = 33'(sr4_q);
      MODE_MUL, MODE_SCREEN, MODE_HARD, MODE_BLEND, MODE_BC:      val = 33'(r4_q);
      MODE_OVERLAY, MODE_SOFT:                                    val = 33'(m3);
      default:                                                    val = 33'(divres);
    endcase
  end

  always_comb begin
    if (val > 33'sd32767) begin
      sat_d = 16'sh7fff;
    end else if (val < -33'sd32768) begin
      sat_d = 16'sh8000;
    end else begin
      sat_d = val[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      res_o <= sat_d;
      zd_o  <= zd4_q;
    end
  end

endmodule

FILE: rtl/spectral_blend_mode_alu.sv
// spectral blend-mode alu: five register stages; an accepted input passes stages one to
// four and then the output register before its result can transfer
// throughput one item per cycle; a stalled output freezes the whole pipeline
// the fixed q4.12 divider runs 4 quotient bits per stage, which sets the depth
// reset (async, active low) clears the valid bits and the mode register to add
// depends on sbm_pkg, sbm_if and sbm_lane
module spectral_blend_mode_alu #(
  parameter int unsigned LANES = sbm_pkg::LANES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  sbm_in_if.sink                       in_i,
  sbm_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sbm_pkg::PADDR_W-1:0]  paddr,
  input  logic [sbm_pkg::PDATA_W-1:0]  pwdata,
  output logic [sbm_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import sbm_pkg::*;

  // configuration: one register, mode, decoded from paddr[2] alone (byte addresses 0 to 3)
  mode_e mode_q;
  logic  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ADD;
    end else if (cfg_wr) begin
      mode_q <= mode_e'(pwdata[3:0]);
    end
  end

  assign prdata = (paddr[2] == REG_MODE) ? PDATA_W'(mode_q) : '0;

  // pipeline control: every stage advances together, valid bits ride along
  logic [PIPE_STAGES-1:0] vld_q;
  logic                   adv;
  lane_ctrl_t             ctrl;

  // the pipeline moves whenever the output register is empty or being drained
  assign adv        = !vld_q[PIPE_STAGES-1] || out_o.ready;
  assign in_i.ready = adv;
  assign out_o.valid = vld_q[PIPE_STAGES-1];
  assign ctrl.en    = adv;
  assign ctrl.mode  = mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_STAGES-2:0], in_i.valid};
    end
  end

  // lanes
  logic [LANES-1:0] zd;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    sbm_lane u_lane (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .a_i    (in_i.a_lane[g]),
      .b_i    (in_i.b_lane[g]),
      .f_i    (in_i.mix_factor),
      .br_i   (in_i.brightness),
      .ct_i   (in_i.contrast),
      .res_o  (out_o.r_lane[g]),
      .zd_o   (zd[g])
    );
  end

  // flag any lane that hit a zero divisor on this transfer
  assign out_o.zero_divide = |zd;

  // checks
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("input stalled while output register empty");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> vld_q[0])
    else $error("accepted transfer missing from first stage");

  a_last_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && vld_q[PIPE_STAGES-2]) |=> out_o.valid)
    else $error("item lost before output register");

endmodule
